// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int TICKS_W  = 12;
  localparam int TIME_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int TDATA_W  = 8;

  localparam logic [TICKS_W-1:0] HOLD_MAX = '1;

  localparam logic [CFG_AW-1:0] REG_MIN_SHORT = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_SHORT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LONG      = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DBL_WIN   = 2'd3;

  localparam logic [TICKS_W-1:0] MIN_SHORT_RST = 12'd10;
  localparam logic [TICKS_W-1:0] MAX_SHORT_RST = 12'd900;
  localparam logic [TICKS_W-1:0] LONG_RST      = 12'd2000;
  localparam logic [TIME_W-1:0]  DBL_WIN_RST   = 16'd300;

  typedef struct packed {
    logic [TICKS_W-1:0] min_short_ticks;
    logic [TICKS_W-1:0] max_short_ticks;
    logic [TICKS_W-1:0] long_ticks;
    logic [TIME_W-1:0]  double_window;
  } cfg_t;

  typedef struct packed {
    logic double_press;
    logic long_press;
    logic short_press;
  } res_t;

endpackage

// ----- sv/bpc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_core
// press classification state and next-result logic, one item per step
// ----------------------------------------------------------------------------
module bpc_core #(
  parameter int TIME_LIMIT = 65000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          tick,
  input  logic          key_level,
  input  bpc_pkg::cfg_t cfg,
  output bpc_pkg::res_t res
);

  localparam int TW = bpc_pkg::TIME_W;
  localparam int HW = bpc_pkg::TICKS_W;
  localparam logic [TW:0] LIMIT = (TW+1)'(TIME_LIMIT);

  logic [TW-1:0] time_r, time_nxt;
  logic [HW-1:0] hold_r, hold_nxt;
  logic          long_seen_r, long_seen_nxt;
  logic          pend_r, pend_nxt;
  logic [TW-1:0] first_r, first_nxt;

  logic [TW:0]   time_inc;
  logic [HW-1:0] hold_inc;
  logic [TW-1:0] elapsed;
  logic          short_ok;
  logic          mid_hold;

  always_comb begin
    time_nxt      = time_r;
    hold_nxt      = hold_r;
    long_seen_nxt = long_seen_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    res           = '0;

    time_inc = {1'b0, time_r} + 1'b1;
    if (time_inc > LIMIT) begin
      time_nxt = '0;
    end else begin
      time_nxt = time_inc[TW-1:0];
    end

    if (({1'b0, hold_r} < ({1'b0, cfg.long_ticks} + 1'b1)) &&
        (hold_r < bpc_pkg::HOLD_MAX)) begin
      hold_inc = hold_r + 1'b1;
    end else begin
      hold_inc = hold_r;
    end

    elapsed  = time_nxt - first_r;
    short_ok = (hold_r > cfg.min_short_ticks) && (hold_r < cfg.max_short_ticks);
    mid_hold = (hold_r >= cfg.max_short_ticks) && (hold_r < cfg.long_ticks);

    if (!tick) begin
      time_nxt = time_r;
    end else if (!key_level) begin
      // key held
      hold_nxt = hold_inc;
      if (hold_inc == cfg.long_ticks) begin
        hold_nxt      = '0;
        res.long_press = 1'b1;
        long_seen_nxt = 1'b1;
        pend_nxt      = 1'b0;
        first_nxt     = '0;
      end
    end else begin
      // key released
      if (short_ok) begin
        if (!long_seen_r) begin
          res.short_press = 1'b1;
          if (!pend_r) begin
            pend_nxt  = 1'b1;
            first_nxt = time_nxt;
          end else begin
            res.double_press = (elapsed < cfg.double_window);
            pend_nxt  = 1'b0;
            first_nxt = '0;
          end
        end
      end else if (mid_hold) begin
        pend_nxt  = 1'b0;
        first_nxt = '0;
      end else if (pend_r && (elapsed >= cfg.double_window)) begin
        pend_nxt  = 1'b0;
        first_nxt = '0;
      end
      hold_nxt      = '0;
      long_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      hold_r      <= '0;
      long_seen_r <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= '0;
    end else if (step) begin
      time_r      <= time_nxt;
      hold_r      <= hold_nxt;
      long_seen_r <= long_seen_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
    end
  end

endmodule

// ----- sv/button_press_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_top
// short, long and double press detection from a ticked active-low key
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// in_       in   tvalid / tready   tdata[0] tick, tdata[1] key_level
// out_      out  tvalid / tready   tdata[0] short, [1] long, [2] double
// cfg_      in   we                addr = register index, wdata
//
// one item per cycle sustained while out_tready stays high; an accepted item
// passes through the input register, then the result register, to the output
// the classifier state updates as the item moves into the result register
// a stalled output holds its item; in_tready drops only when both registers
// are full and out_tready is low
// synchronous active-low reset clears state and loads the register defaults
// ----------------------------------------------------------------------------
module button_press_classifier_top #(
  parameter int TIME_LIMIT = 65000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bpc_pkg::TDATA_W-1:0]  in_tdata,   // tick, key_level
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bpc_pkg::TDATA_W-1:0]  out_tdata,  // short_press, long_press, double_press
  input  logic                         cfg_we,
  input  logic [bpc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bpc_pkg::CFG_W-1:0]    cfg_wdata
);

  bpc_pkg::cfg_t cfg_r;
  bpc_pkg::res_t res;
  bpc_pkg::res_t res_r;

  logic in_valid_r;
  logic tick_r;
  logic key_r;
  logic out_valid_r;
  logic out_adv;
  logic step;

  assign out_adv   = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_adv;
  assign in_tready = !in_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_short_ticks <= bpc_pkg::MIN_SHORT_RST;
      cfg_r.max_short_ticks <= bpc_pkg::MAX_SHORT_RST;
      cfg_r.long_ticks      <= bpc_pkg::LONG_RST;
      cfg_r.double_window   <= bpc_pkg::DBL_WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bpc_pkg::REG_MIN_SHORT: cfg_r.min_short_ticks <= cfg_wdata[bpc_pkg::TICKS_W-1:0];
        bpc_pkg::REG_MAX_SHORT: cfg_r.max_short_ticks <= cfg_wdata[bpc_pkg::TICKS_W-1:0];
        bpc_pkg::REG_LONG:      cfg_r.long_ticks      <= cfg_wdata[bpc_pkg::TICKS_W-1:0];
        bpc_pkg::REG_DBL_WIN:   cfg_r.double_window   <= cfg_wdata[bpc_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r <= in_tdata[0];
      key_r  <= in_tdata[1];
    end
  end

  bpc_core #(
    .TIME_LIMIT (TIME_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .tick      (tick_r),
    .key_level (key_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bpc_pkg::TDATA_W-3){1'b0}},
                       res_r.double_press, res_r.long_press, res_r.short_press};

endmodule
